### src/alarm_clock_drive_controller_assert.svh
// ---------------------------------------------------------------------------
// Alarm clock drive controller assertion macros
// Shared concurrent check forms; each expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ALARM_CLOCK_DRIVE_CONTROLLER_ASSERT_SVH
`define ALARM_CLOCK_DRIVE_CONTROLLER_ASSERT_SVH

// Condition holds at every edge out of reset.
`define ACDC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ACDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ACDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/acdc_pkg.sv
// ---------------------------------------------------------------------------
// Alarm clock drive controller package
// Request and result types, register map, reset values and constants.
// ---------------------------------------------------------------------------
package acdc_pkg;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_ALARM_SEC  = 3'd0,
    REG_ALARM_MIN  = 3'd1,
    REG_ALARM_HR   = 3'd2,
    REG_ALARM_EN   = 3'd3,
    REG_TICKS_SEC  = 3'd4,
    REG_DRIVE_TCKS = 3'd5,
    REG_MIN_CM     = 3'd6,
    REG_MAX_CM     = 3'd7
  } reg_idx_t;

  // Request kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_ECHO = 1'b1;

  // cm = ((count * CM_MULT) >> CM_SHIFT) + 1, i.e. count / 58.82 + 1
  localparam logic [14:0] CM_MULT  = 15'd17827;
  localparam int          CM_SHIFT = 20;

  localparam logic [5:0] SEC_PER_MIN = 6'd60;
  localparam logic [5:0] MIN_PER_HR  = 6'd60;
  localparam logic [4:0] HR_PER_DAY  = 5'd24;

  localparam logic [5:0]  RST_ALARM_SEC  = 6'd15;
  localparam logic [5:0]  RST_ALARM_MIN  = 6'd0;
  localparam logic [4:0]  RST_ALARM_HR   = 5'd0;
  localparam logic        RST_ALARM_EN   = 1'b1;
  localparam logic [15:0] RST_TICKS_SEC  = 16'd1000;
  localparam logic [15:0] RST_DRIVE_TCKS = 16'd1000;
  localparam logic [10:0] RST_MIN_CM     = 11'd2;
  localparam logic [10:0] RST_MAX_CM     = 11'd300;

  typedef struct packed {
    logic        kind;
    logic        button;
    logic [15:0] echo_count;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic        run_mode;
    logic        buzzer;
    logic        drive_out;
    logic [10:0] distance_cm;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  alarm_seconds;
    logic [5:0]  alarm_minutes;
    logic [4:0]  alarm_hours;
    logic        alarm_enable;
    logic [15:0] ticks_per_second;
    logic [15:0] drive_ticks;
    logic [10:0] min_cm;
    logic [10:0] max_cm;
  } cfg_t;

  // Request after the input register: echo already converted to cm
  typedef struct packed {
    logic        kind;
    logic        button;
    logic [10:0] cm;
  } stage_t;

endpackage

### src/acdc_regs.sv
// ---------------------------------------------------------------------------
// Alarm clock drive controller configuration registers
// APB-style register file holding alarm time, tick rate and range limits.
// ---------------------------------------------------------------------------
module acdc_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [acdc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [acdc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [acdc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output acdc_pkg::cfg_t                    cfg
);
  import acdc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_ALARM_SEC:  cfg_nxt.alarm_seconds    = pwdata[5:0];
        REG_ALARM_MIN:  cfg_nxt.alarm_minutes    = pwdata[5:0];
        REG_ALARM_HR:   cfg_nxt.alarm_hours      = pwdata[4:0];
        REG_ALARM_EN:   cfg_nxt.alarm_enable     = pwdata[0];
        REG_TICKS_SEC:  cfg_nxt.ticks_per_second = pwdata[15:0];
        REG_DRIVE_TCKS: cfg_nxt.drive_ticks      = pwdata[15:0];
        REG_MIN_CM:     cfg_nxt.min_cm           = pwdata[10:0];
        REG_MAX_CM:     cfg_nxt.max_cm           = pwdata[10:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ALARM_SEC:  prdata = CFG_DATA_W'(cfg_r.alarm_seconds);
      REG_ALARM_MIN:  prdata = CFG_DATA_W'(cfg_r.alarm_minutes);
      REG_ALARM_HR:   prdata = CFG_DATA_W'(cfg_r.alarm_hours);
      REG_ALARM_EN:   prdata = CFG_DATA_W'(cfg_r.alarm_enable);
      REG_TICKS_SEC:  prdata = CFG_DATA_W'(cfg_r.ticks_per_second);
      REG_DRIVE_TCKS: prdata = CFG_DATA_W'(cfg_r.drive_ticks);
      REG_MIN_CM:     prdata = CFG_DATA_W'(cfg_r.min_cm);
      REG_MAX_CM:     prdata = CFG_DATA_W'(cfg_r.max_cm);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alarm_seconds    <= RST_ALARM_SEC;
      cfg_r.alarm_minutes    <= RST_ALARM_MIN;
      cfg_r.alarm_hours      <= RST_ALARM_HR;
      cfg_r.alarm_enable     <= RST_ALARM_EN;
      cfg_r.ticks_per_second <= RST_TICKS_SEC;
      cfg_r.drive_ticks      <= RST_DRIVE_TCKS;
      cfg_r.min_cm           <= RST_MIN_CM;
      cfg_r.max_cm           <= RST_MAX_CM;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### src/acdc_ingress.sv
// ---------------------------------------------------------------------------
// Alarm clock drive controller input stage
// Input register; converts the echo count to centimetres on the way in.
// ---------------------------------------------------------------------------
module acdc_ingress (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  acdc_pkg::in_item_t   in_data,
  input  logic                 core_ready,
  output logic                 s1_valid,
  output acdc_pkg::stage_t     s1_item
);
  import acdc_pkg::*;

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  stage_t      s1_item_r;
  stage_t      s1_item_nxt;
  logic        load;
  logic [30:0] product;

  // Hold the staged request until the core takes it
  assign in_ready = !s1_valid_r || core_ready;
  assign load     = in_valid && in_ready;

  assign product = 31'(in_data.echo_count) * 31'(CM_MULT);

  always_comb begin
    s1_item_nxt.kind   = in_data.kind;
    s1_item_nxt.button = in_data.button;
    s1_item_nxt.cm     = product[CM_SHIFT+10:CM_SHIFT] + 11'd1;
  end

  always_comb begin
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (core_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r <= s1_item_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

### src/acdc_core.sv
// ---------------------------------------------------------------------------
// Alarm clock drive controller core
// Clock, alarm and drive state update with the result register.
// ---------------------------------------------------------------------------
`include "alarm_clock_drive_controller_assert.svh"

module acdc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  acdc_pkg::cfg_t       cfg,
  input  logic                 s1_valid,
  input  acdc_pkg::stage_t     s1_item,
  output logic                 core_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output acdc_pkg::out_item_t  out_data
);
  import acdc_pkg::*;

  logic [15:0] tick_r, tick_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic        mode_r, mode_nxt;
  logic        buzz_r, buzz_nxt;
  logic        drive_r, drive_nxt;
  logic [15:0] cntdn_r, cntdn_nxt;
  logic [10:0] last_cm_r, last_cm_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        advance;
  logic [15:0] tick_inc;
  logic [5:0]  sec_inc;
  logic [5:0]  min_inc;
  logic [4:0]  hour_inc;

  assign core_ready = !out_valid_r || out_ready;
  assign advance    = s1_valid && core_ready;

  assign tick_inc = tick_r + 16'd1;
  assign sec_inc  = sec_r + 6'd1;
  assign min_inc  = min_r + 6'd1;
  assign hour_inc = hour_r + 5'd1;

  always_comb begin
    tick_nxt    = tick_r;
    sec_nxt     = sec_r;
    min_nxt     = min_r;
    hour_nxt    = hour_r;
    mode_nxt    = mode_r;
    buzz_nxt    = buzz_r;
    drive_nxt   = drive_r;
    cntdn_nxt   = cntdn_r;
    last_cm_nxt = last_cm_r;

    if (s1_item.kind == KIND_TICK) begin
      tick_nxt = tick_inc;
      if (tick_inc >= cfg.ticks_per_second) begin
        tick_nxt = 16'd0;
        // Advance hh:mm:ss with carries
        if (sec_inc >= SEC_PER_MIN) begin
          sec_nxt = 6'd0;
          if (min_inc >= MIN_PER_HR) begin
            min_nxt = 6'd0;
            hour_nxt = (hour_inc >= HR_PER_DAY) ? 5'd0 : hour_inc;
          end else begin
            min_nxt = min_inc;
          end
        end else begin
          sec_nxt = sec_inc;
        end
        if (cfg.alarm_enable && (sec_nxt == cfg.alarm_seconds) &&
            (min_nxt == cfg.alarm_minutes) && (hour_nxt == cfg.alarm_hours)) begin
          mode_nxt = 1'b1;
          buzz_nxt = 1'b1;
        end
      end
      if (cntdn_r != 16'd0) begin
        cntdn_nxt = cntdn_r - 16'd1;
      end
      // Button wins over an alarm match on the same tick
      if (s1_item.button) begin
        mode_nxt = 1'b0;
        buzz_nxt = 1'b0;
      end
    end else if (!drive_r || (cntdn_r == 16'd0)) begin
      if (mode_r) begin
        last_cm_nxt = s1_item.cm;
        if ((s1_item.cm >= cfg.min_cm) && (s1_item.cm <= cfg.max_cm)) begin
          cntdn_nxt = cfg.drive_ticks;
          drive_nxt = 1'b1;
        end else begin
          drive_nxt = 1'b0;
        end
      end else begin
        drive_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_data_nxt.seconds     = sec_nxt;
    out_data_nxt.minutes     = min_nxt;
    out_data_nxt.hours       = hour_nxt;
    out_data_nxt.run_mode    = mode_nxt;
    out_data_nxt.buzzer      = buzz_nxt;
    out_data_nxt.drive_out   = drive_nxt;
    out_data_nxt.distance_cm = last_cm_nxt;
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= 16'd0;
      sec_r       <= 6'd0;
      min_r       <= 6'd0;
      hour_r      <= 5'd0;
      mode_r      <= 1'b0;
      buzz_r      <= 1'b0;
      drive_r     <= 1'b0;
      cntdn_r     <= 16'd0;
      last_cm_r   <= 11'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        tick_r    <= tick_nxt;
        sec_r     <= sec_nxt;
        min_r     <= min_nxt;
        hour_r    <= hour_nxt;
        mode_r    <= mode_nxt;
        buzz_r    <= buzz_nxt;
        drive_r   <= drive_nxt;
        cntdn_r   <= cntdn_nxt;
        last_cm_r <= last_cm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ACDC_ASSERT_ALWAYS(a_time_range, (sec_r < SEC_PER_MIN) && (min_r < MIN_PER_HR) && (hour_r < HR_PER_DAY), "clock field out of range")
  `ACDC_ASSERT_ALWAYS(a_buzz_mode, buzz_r == mode_r, "buzzer and drive mode disagree")
  `ACDC_ASSERT_NXT(a_cntdn_dec, advance && (s1_item.kind == KIND_TICK) && (cntdn_r != 16'd0), cntdn_r == $past(cntdn_r) - 16'd1, "countdown did not step down on a tick")
  `ACDC_ASSERT_NXT(a_out_load, advance, out_valid_r && (out_data_r.seconds == sec_r) && (out_data_r.drive_out == drive_r), "result does not show the updated state")
  `ACDC_ASSERT_IMP(a_no_drop, out_valid_r && !out_ready, !advance, "pending result overwritten")

endmodule

### src/alarm_clock_drive_controller.sv
// Alarm clock drive controller. Each request is a millisecond tick or an
// ultrasonic echo count and yields exactly one result showing the clock,
// alarm and drive state after it. One request is accepted per cycle while
// in_ready is high; a result passes the input register, then the state update
// into the result register, before it appears in out_data; the input side keeps
// accepting while a result waits on out_ready until both registers are full.
// The echo-to-centimetre multiply sits ahead of the input register, the state
// update behind it. Configuration is written through the APB-style port at
// byte address 4*index and should only change while no request is in flight.
// ---------------------------------------------------------------------------
// Alarm clock drive controller top level
// Ties the configuration registers, input stage and state core together.
// ---------------------------------------------------------------------------
module alarm_clock_drive_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  acdc_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output acdc_pkg::out_item_t               out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [acdc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [acdc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [acdc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import acdc_pkg::*;

  cfg_t   cfg;
  stage_t s1_item;
  logic   s1_valid;
  logic   core_ready;

  acdc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  acdc_ingress u_ingress (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .core_ready (core_ready),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item)
  );

  acdc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item),
    .core_ready (core_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
